// File: rtl/tile_sprite_pixel_compositor_core_defines.svh
// Assertion macros for the compositor RTL
`ifndef TILE_SPRITE_PIXEL_COMPOSITOR_CORE_DEFINES_SVH
`define TILE_SPRITE_PIXEL_COMPOSITOR_CORE_DEFINES_SVH

// Concurrent check clocked on clk_i, held off while rst_ni is low
`define TSPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check with an explicit clock and active-low reset
`define TSPC_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`endif

// File: rtl/tspc_pkg.sv
// Shared types and codes of the tile and sprite pixel compositor
package tspc_pkg;

  typedef enum logic [2:0] {
    MODE_PATTERN = 3'd0,
    MODE_PALETTE = 3'd1,
    MODE_MAP     = 3'd2,
    MODE_SPRITE  = 3'd3,
    MODE_RENDER  = 3'd4
  } tspc_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_BG_MAP,
    ST_BG_PAT,
    ST_PAL,
    ST_OUT
  } tspc_state_e;

  typedef enum logic {
    REG_SCROLL_X = 1'b0,
    REG_SCROLL_Y = 1'b1
  } tspc_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic issue;
    logic map_rd;
    logic bg_pat;
    logic pal_rd;
    logic out;
  } tspc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic render_go;
  } tspc_status_t;

endpackage

// File: rtl/tspc_ctrl.sv
// Sequencer for item acceptance, sprite scan, background and palette lookups
`include "tile_sprite_pixel_compositor_core_defines.svh"
module tspc_ctrl #(
  parameter int SPRITE_COUNT = 128,
  parameter int SIDX_W = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tspc_pkg::tspc_status_t status_i,
  output tspc_pkg::tspc_cmd_t    cmd_o,
  output logic [SIDX_W-1:0]     idx_o,
  output logic                  busy_o
);
  import tspc_pkg::*;

  tspc_state_e       state_q, state_d;
  logic [SIDX_W-1:0] cnt_q, cnt_d;
  logic              last;

  assign last  = (cnt_q == SIDX_W'(SPRITE_COUNT - 1));
  assign idx_o = cnt_q;

  // State and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
        cnt_d        = '0;
        if (start_i && status_i.render_go) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (last) state_d = ST_DRAIN1;
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_BG_MAP;
      ST_BG_MAP: begin
        cmd_o.map_rd = 1'b1;
        state_d      = ST_BG_PAT;
      end
      ST_BG_PAT: begin
        cmd_o.bg_pat = 1'b1;
        state_d      = ST_PAL;
      end
      ST_PAL: begin
        cmd_o.pal_rd = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.out = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `TSPC_ASSERT(a_out_single, cmd_o.out |=> !cmd_o.out, "result strobe held two cycles")
  `TSPC_ASSERT(a_out_after_pal, cmd_o.out |-> $past(cmd_o.pal_rd), "result without palette read")
  `TSPC_ASSERT(a_render_busy, (cmd_o.accept && status_i.render_go) |=> busy_o,
    "render item accepted but block not busy")

endmodule

// File: rtl/tspc_datapath.sv
// Memories, sprite hit pipeline, background lookup and colour output
module tspc_datapath #(
  parameter int SPRITE_COUNT  = 128,
  parameter int PATTERN_COUNT = 256,
  parameter int MAP_SIDE      = 64,
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256,
  parameter int SIDX_W        = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tspc_pkg::tspc_cmd_t    cmd_i,
  input  logic [SIDX_W-1:0]      idx_i,
  output tspc_pkg::tspc_status_t status_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [9:0]             cfg_data_i,
  input  logic [2:0]             mode_i,
  input  logic [7:0]             table_index_i,
  input  logic [6:0]             byte_offset_i,
  input  logic [5:0]             map_column_i,
  input  logic [5:0]             map_row_i,
  input  logic [15:0]            value_word_i,
  input  logic signed [9:0]      sprite_x_i,
  input  logic signed [9:0]      sprite_y_i,
  input  logic                   sprite_enable_i,
  input  logic [7:0]             screen_x_i,
  input  logic [7:0]             screen_y_i,
  output logic                   result_valid_o,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o
);
  import tspc_pkg::*;

  localparam int PDEPTH  = PATTERN_COUNT * 128;
  localparam int PADDR_W = $clog2(PDEPTH);
  localparam int MDEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int MADDR_W = $clog2(MDEPTH);

  // 6-bit channel to 8-bit: v*255/63 = 4v + v/21
  function automatic logic [7:0] expand(input logic [4:0] v5, input logic i);
    logic [5:0] v6;
    logic [1:0] q;
    v6 = {v5, i};
    q  = (v6 >= 6'd63) ? 2'd3 : (v6 >= 6'd42) ? 2'd2 : (v6 >= 6'd21) ? 2'd1 : 2'd0;
    return {v6, 2'b00} + {6'd0, q};
  endfunction

  // Tile number modulo the map side, by repeated subtraction
  function automatic logic [6:0] wrap_tile(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    for (int k = 0; k < 6; k++) begin
      if (r >= 7'(MAP_SIDE)) r = r - 7'(MAP_SIDE);
    end
    return r;
  endfunction

  // Memories
  logic [7:0]  pat_mem [PDEPTH];
  logic [23:0] pal_mem [256];
  logic [15:0] map_mem [MDEPTH];
  logic [35:0] spr_mem [SPRITE_COUNT];
  logic [255:0]          pal_valid_q;
  logic [SPRITE_COUNT-1:0] shown_q;

  logic [9:0] scroll_x_q, scroll_y_q;
  logic [7:0] sx_q, sy_q;

  logic we_pat, we_pal, we_map, we_spr;
  assign we_pat = cmd_i.accept && (mode_i == MODE_PATTERN) &&
                  ({1'b0, table_index_i} < 9'(PATTERN_COUNT));
  assign we_pal = cmd_i.accept && (mode_i == MODE_PALETTE);
  assign we_map = cmd_i.accept && (mode_i == MODE_MAP) &&
                  ({1'b0, map_column_i} < 7'(MAP_SIDE)) && ({1'b0, map_row_i} < 7'(MAP_SIDE));
  assign we_spr = cmd_i.accept && (mode_i == MODE_SPRITE) &&
                  ({1'b0, table_index_i} < 9'(SPRITE_COUNT));

  assign status_o.render_go = (mode_i == MODE_RENDER) &&
                              ({2'b0, screen_x_i} < 10'(SCREEN_WIDTH)) &&
                              ({2'b0, screen_y_i} < 10'(SCREEN_HEIGHT));

  logic [14:0] pat_wfull;
  logic [12:0] map_wfull;
  logic [23:0] pal_wdata;
  assign pat_wfull = {table_index_i, byte_offset_i};
  assign map_wfull = 13'(map_row_i) * 13'(MAP_SIDE) + 13'(map_column_i);
  assign pal_wdata = {expand(value_word_i[10:6], value_word_i[0]),
                      expand(value_word_i[15:11], value_word_i[0]),
                      expand(value_word_i[5:1], value_word_i[0])};

  // Configuration and control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q  <= '0;
      scroll_y_q  <= '0;
      pal_valid_q <= '0;
      shown_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCROLL_X: scroll_x_q <= cfg_data_i;
          REG_SCROLL_Y: scroll_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (we_pal) pal_valid_q[table_index_i] <= 1'b1;
      if (we_spr) shown_q[table_index_i[SIDX_W-1:0]] <= sprite_enable_i;
    end
  end

  // Latch the pixel coordinates of an accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sx_q <= screen_x_i;
      sy_q <= screen_y_i;
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (we_pat) pat_mem[pat_wfull[PADDR_W-1:0]] <= value_word_i[7:0];
    if (we_pal) pal_mem[table_index_i] <= pal_wdata;
    if (we_map) map_mem[map_wfull[MADDR_W-1:0]] <= value_word_i;
    if (we_spr) spr_mem[table_index_i[SIDX_W-1:0]] <= {sprite_x_i, sprite_y_i, value_word_i};
  end

  // Stage A: sprite entry read
  logic [35:0] spr_q;
  logic        spr_v_q;
  always_ff @(posedge clk_i) begin
    spr_q <= spr_mem[idx_i];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spr_v_q <= 1'b0;
    else         spr_v_q <= cmd_i.issue && shown_q[idx_i];
  end

  // Background map read
  logic [10:0] wx, wy;
  logic [6:0]  tcol, trow;
  logic [12:0] map_rfull;
  logic [15:0] map_q;
  assign wx        = {3'b0, sx_q} + {1'b0, scroll_x_q};
  assign wy        = {3'b0, sy_q} + {1'b0, scroll_y_q};
  assign tcol      = wrap_tile(wx[10:4]);
  assign trow      = wrap_tile(wy[10:4]);
  assign map_rfull = 13'(trow) * 13'(MAP_SIDE) + 13'(tcol);
  always_ff @(posedge clk_i) begin
    if (cmd_i.map_rd) map_q <= map_mem[map_rfull[MADDR_W-1:0]];
  end

  // Stage B: coverage test and pattern read, shared with the background
  logic signed [11:0] dx, dy;
  logic        covered;
  logic [15:0] attr;
  logic [3:0]  px, py;
  logic        tile_ok;
  logic [14:0] pat_rfull;
  assign dx    = $signed({4'b0, sx_q}) - $signed({{2{spr_q[35]}}, spr_q[35:26]});
  assign dy    = $signed({4'b0, sy_q}) - $signed({{2{spr_q[25]}}, spr_q[25:16]});
  assign covered = (dx[11:4] == 8'd0) && (dy[11:4] == 8'd0);
  assign attr  = cmd_i.bg_pat ? map_q : spr_q[15:0];
  assign px    = (cmd_i.bg_pat ? wx[3:0] : dx[3:0]) ^ {4{attr[14]}};
  assign py    = (cmd_i.bg_pat ? wy[3:0] : dy[3:0]) ^ {4{attr[15]}};
  assign tile_ok   = {1'b0, attr[7:0]} < 9'(PATTERN_COUNT);
  assign pat_rfull = {attr[7:0], py, px[3:1]};

  logic [7:0] pat_q;
  logic [3:0] bank_q;
  logic       px0_q, ok_q, b_v_q;
  always_ff @(posedge clk_i) begin
    pat_q  <= pat_mem[pat_rfull[PADDR_W-1:0]];
    bank_q <= attr[11:8];
    px0_q  <= px[0];
    ok_q   <= tile_ok;
  end

  // Stage C: first opaque sprite wins
  logic [3:0] nib;
  logic       hit_q;
  logic [7:0] col_q;
  assign nib = ok_q ? (px0_q ? pat_q[3:0] : pat_q[7:4]) : 4'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      b_v_q <= spr_v_q && covered;
      if (cmd_i.accept) hit_q <= 1'b0;
      else if (b_v_q && !hit_q && nib != 4'd0) hit_q <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (b_v_q && !hit_q && nib != 4'd0) col_q <= {bank_q, nib};
  end

  // Palette read and result
  logic [7:0]  pal_addr;
  logic [23:0] pal_q;
  logic        pal_v_q;
  assign pal_addr = hit_q ? col_q : (nib != 4'd0) ? {bank_q, nib} : 8'd0;
  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_rd) begin
      pal_q   <= pal_mem[pal_addr];
      pal_v_q <= pal_valid_q[pal_addr];
    end
  end

  assign result_valid_o = cmd_i.out;
  assign red_o   = pal_v_q ? pal_q[23:16] : 8'd0;
  assign green_o = pal_v_q ? pal_q[15:8]  : 8'd0;
  assign blue_o  = pal_v_q ? pal_q[7:0]   : 8'd0;

endmodule

// File: rtl/tile_sprite_pixel_compositor_core.sv
// The sprite scan reads one sprite entry per cycle through a three-stage pipeline,
// then map, pattern and palette reads follow; write items are stored when accepted.
// Items are taken only while idle: one write item per cycle; result_valid_o pulses once.
// rst_ni is asynchronous, active low; it clears scroll, palette valid bits and shown bits.
// Results cannot be stalled by the receiver.
module tile_sprite_pixel_compositor_core #(
  parameter int SPRITE_COUNT  = 128,
  parameter int PATTERN_COUNT = 256,
  parameter int MAP_SIDE      = 64,
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [9:0]        cfg_data_i,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        table_index_i,
  input  logic [6:0]        byte_offset_i,
  input  logic [5:0]        map_column_i,
  input  logic [5:0]        map_row_i,
  input  logic [15:0]       value_word_i,
  input  logic signed [9:0] sprite_x_i,
  input  logic signed [9:0] sprite_y_i,
  input  logic              sprite_enable_i,
  input  logic [7:0]        screen_x_i,
  input  logic [7:0]        screen_y_i,
  output logic              result_valid_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o
);
  import tspc_pkg::*;

  localparam int SIDX_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

  tspc_cmd_t         cmd;
  tspc_status_t      status;
  logic [SIDX_W-1:0] idx;

  tspc_ctrl #(
    .SPRITE_COUNT(SPRITE_COUNT),
    .SIDX_W      (SIDX_W)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .cmd_o   (cmd),
    .idx_o   (idx),
    .busy_o  (busy)
  );

  tspc_datapath #(
    .SPRITE_COUNT (SPRITE_COUNT),
    .PATTERN_COUNT(PATTERN_COUNT),
    .MAP_SIDE     (MAP_SIDE),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .SIDX_W       (SIDX_W)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .table_index_i  (table_index_i),
    .byte_offset_i  (byte_offset_i),
    .map_column_i   (map_column_i),
    .map_row_i      (map_row_i),
    .value_word_i   (value_word_i),
    .sprite_x_i     (sprite_x_i),
    .sprite_y_i     (sprite_y_i),
    .sprite_enable_i(sprite_enable_i),
    .screen_x_i     (screen_x_i),
    .screen_y_i     (screen_y_i),
    .result_valid_o (result_valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o)
  );

endmodule
